>>> sv/wss_pkg.sv
package wss_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int WINDOW_DEPTH = 1024;
  localparam int COUNT_WIDTH  = 11;

  localparam logic KIND_PUSH   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic                           kind;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } wss_cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] average;
    logic signed [SAMPLE_WIDTH-1:0] minimum;
    logic signed [SAMPLE_WIDTH-1:0] maximum;
    logic        [COUNT_WIDTH-1:0]  sample_count;
  } wss_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_LAUNCH,
    ST_DIVIDE
  } wss_state_t;

endpackage

>>> sv/wss_ring.sv
module wss_ring #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/wss_div.sv
module wss_div #(
  parameter int SUM_WIDTH = 27,
  parameter int CNT_WIDTH = 11,
  parameter int Q_WIDTH   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [SUM_WIDTH-1:0] dividend,
  input  logic        [CNT_WIDTH-1:0] divisor,
  output logic                        done,
  output logic signed [Q_WIDTH-1:0]   quotient
);

  localparam int STEP_W = $clog2(SUM_WIDTH + 1);

  logic                 active;
  logic                 neg;
  logic [STEP_W-1:0]    step;
  logic [SUM_WIDTH-1:0] quo;
  logic [CNT_WIDTH-1:0] rem;
  logic [CNT_WIDTH-1:0] dvs;
  logic [CNT_WIDTH:0]   shifted;
  logic                 fits;
  logic [CNT_WIDTH:0]   rem_next;
  logic [SUM_WIDTH-1:0] magnitude;
  logic [Q_WIDTH-1:0]   q_low;

  // One quotient bit per cycle, restoring form on the magnitude.
  always_comb begin
    shifted   = {rem, quo[SUM_WIDTH-1]};
    fits      = shifted >= {1'b0, dvs};
    rem_next  = fits ? (shifted - {1'b0, dvs}) : shifted;
    magnitude = dividend[SUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;
    q_low     = quo[Q_WIDTH-1:0];
    quotient  = neg ? signed'(~q_low + 1'b1) : signed'(q_low);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && step == STEP_W'(1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[SUM_WIDTH-1];
      quo  <= magnitude;
      rem  <= '0;
      dvs  <= divisor;
      step <= STEP_W'(SUM_WIDTH);
    end else if (active) begin
      rem  <= rem_next[CNT_WIDTH-1:0];
      quo  <= {quo[SUM_WIDTH-2:0], fits};
      step <= step - 1'b1;
    end
  end

endmodule

>>> sv/window_sample_statistics.sv
// Sliding-window statistics over the newest WINDOW_DEPTH signed samples (1/16 degree units).
// A push (kind 0) is taken while busy is low and leaves it low, so pushes can follow every cycle
// while no report is in progress. A report (kind 1) on a non-empty window holds busy high while
// the ring memory is read one entry per cycle, oldest to newest, then while a bit-serial divider
// forms the average. The single read port of the ring memory sets the walk length and the divider
// works through the sum bit by bit. The result appears on result, marked by strobe, which is high
// for exactly one cycle; it cannot be held off, so the receiver must take it in that cycle. A report
// on an empty window returns all zeros in the cycle after the transfer. sample_count carries the
// low 11 bits of the fill count.
module window_sample_statistics #(
  parameter int WINDOW_DEPTH = wss_pkg::WINDOW_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  wss_pkg::wss_cmd_t    cmd,
  output logic                 strobe,
  output wss_pkg::wss_result_t result
);

  import wss_pkg::*;

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;

  wss_state_t state, state_next;

  logic                           take;
  logic                           push;
  logic                           report;
  logic                           rd_en;
  logic                           div_start;
  logic                           div_done;
  logic signed [SAMPLE_WIDTH-1:0] div_quotient;
  logic        [ADDR_W-1:0]       wr_ptr;
  logic        [CNT_W-1:0]        fill;
  logic        [ADDR_W-1:0]       rd_addr;
  logic        [CNT_W-1:0]        remaining;
  logic                           data_valid;
  logic                           first;
  logic signed [SUM_W-1:0]        sum;
  logic signed [SAMPLE_WIDTH-1:0] lo;
  logic signed [SAMPLE_WIDTH-1:0] hi;
  logic        [SAMPLE_WIDTH-1:0] rd_data;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic        [CNT_W:0]          base;
  logic        [ADDR_W-1:0]       oldest;

  assign take      = start && !busy;
  assign push      = take && cmd.kind == KIND_PUSH;
  assign report    = take && cmd.kind == KIND_REPORT;
  assign sample_in = signed'(rd_data);

  // Oldest entry sits fill slots behind the write pointer, modulo the depth.
  always_comb begin
    base = (CNT_W + 1)'(wr_ptr) + (CNT_W + 1)'(WINDOW_DEPTH) - (CNT_W + 1)'(fill);
    if (base >= (CNT_W + 1)'(WINDOW_DEPTH)) begin
      base = base - (CNT_W + 1)'(WINDOW_DEPTH);
    end
    oldest = base[ADDR_W-1:0];
  end

  wss_ring #(
    .DEPTH (WINDOW_DEPTH),
    .WIDTH (SAMPLE_WIDTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (wr_ptr),
    .wr_data (cmd.sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wss_div #(
    .SUM_WIDTH (SUM_W),
    .CNT_WIDTH (CNT_W),
    .Q_WIDTH   (SAMPLE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (fill),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (report && fill != '0) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (remaining == CNT_W'(1)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH:  state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    rd_en     = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_IDLE:   busy = 1'b0;
      ST_WALK:   rd_en = 1'b1;
      ST_LAUNCH: div_start = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wr_ptr     <= '0;
      fill       <= '0;
      data_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      data_valid <= rd_en;
      strobe     <= 1'b0;
      if (push) begin
        wr_ptr <= (wr_ptr == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        if (fill != CNT_W'(WINDOW_DEPTH)) begin
          fill <= fill + 1'b1;
        end
      end
      if ((report && fill == '0) || div_done) begin
        strobe <= 1'b1;
      end
    end
  end

  // Walk the ring and fold each returned sample into sum, min and max.
  always_ff @(posedge clk) begin
    if (report) begin
      rd_addr   <= oldest;
      remaining <= fill;
      first     <= 1'b1;
      sum       <= '0;
    end else if (rd_en) begin
      rd_addr   <= (rd_addr == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
      remaining <= remaining - 1'b1;
    end
    if (data_valid) begin
      sum   <= sum + SUM_W'(sample_in);
      first <= 1'b0;
      if (first || sample_in < lo) begin
        lo <= sample_in;
      end
      if (first || sample_in > hi) begin
        hi <= sample_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (report && fill == '0) begin
      result <= '0;
    end else if (div_done) begin
      result.average      <= div_quotient;
      result.minimum      <= lo;
      result.maximum      <= hi;
      result.sample_count <= COUNT_WIDTH'(fill);
    end
  end

endmodule
